FILE: rtl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// shared types, constants and the arctangent table of the haversine pipeline
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int CORDIC_STEPS = 24;
  // the arctangent table has 31 entries and returns zero beyond them; iterations stop at 32
  localparam int NSTEPS       = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int ISQRT_BITS   = 31;
  // prep 2, rotation NSTEPS, mix 3, root ISQRT_BITS, vectoring NSTEPS, scale 1
  localparam int LATENCY      = 2 * NSTEPS + ISQRT_BITS + 6;

  localparam int CW = 33;
  typedef logic signed [CW-1:0] cw_t;
  typedef logic [30:0]          q30_t;

  localparam logic signed [29:0] LAT_MAX       = 30'sd377487360;
  localparam logic signed [29:0] LAT_MIN       = -30'sd377487360;
  localparam logic signed [31:0] HALF_TURN     = 32'sd754974720;
  localparam logic signed [31:0] NEG_HALF_TURN = -32'sd754974720;
  localparam logic signed [31:0] FULL_TURN     = 32'sd1509949440;
  localparam logic [30:0]        RAD_K         = 31'd1199381129;
  localparam cw_t                CORDIC_GAIN   = 33'sd652032874;
  localparam q30_t               ONE_Q30       = 31'd1073741824;
  localparam q30_t               HALF_PI_Q30   = 31'd1686629713;
  localparam logic [28:0]        EARTH_R_Q16   = 29'd417997455;
  localparam logic [30:0]        DIST_MAX      = 31'd1313210368;

  // atan(2^-i) in q2.30, truncated up to i = 26 and rounded beyond
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] t;
    case (i)
      0:       t = 32'h3243F6A8;
      1:       t = 32'h1DAC6705;
      2:       t = 32'h0FADBAFC;
      3:       t = 32'h07F56EA6;
      4:       t = 32'h03FEAB76;
      5:       t = 32'h01FFD55B;
      6:       t = 32'h00FFFAAA;
      7:       t = 32'h007FFF55;
      8:       t = 32'h003FFFEA;
      9:       t = 32'h001FFFFD;
      10:      t = 32'h000FFFFF;
      11:      t = 32'h0007FFFF;
      12:      t = 32'h0003FFFF;
      13:      t = 32'h0001FFFF;
      14:      t = 32'h0000FFFF;
      15:      t = 32'h00007FFF;
      16:      t = 32'h00003FFF;
      17:      t = 32'h00001FFF;
      18:      t = 32'h00000FFF;
      19:      t = 32'h000007FF;
      20:      t = 32'h000003FF;
      21:      t = 32'h000001FF;
      22:      t = 32'h000000FF;
      23:      t = 32'h0000007F;
      24:      t = 32'h0000003F;
      25:      t = 32'h0000001F;
      26:      t = 32'h0000000F;
      27:      t = 32'h00000008;
      28:      t = 32'h00000004;
      29:      t = 32'h00000002;
      30:      t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  function automatic q30_t clamp_u31(input cw_t v, input q30_t hi);
    q30_t r;
    if (v[CW-1]) begin
      r = '0;
    end else if (v > cw_t'({2'b00, hi})) begin
      r = hi;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/hvd_prep.sv
// ----------------------------------------------------------------------------
// hvd_prep
// latitude clamp, differences, longitude wrap and conversion to radians
// ----------------------------------------------------------------------------
module hvd_prep import hvd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [29:0] lat_a,
  input  logic signed [30:0] lon_a,
  input  logic signed [29:0] lat_b,
  input  logic signed [30:0] lon_b,
  output logic               out_valid,
  output logic [3:0][30:0]   ang
);

  logic               v1_r, v2_r;
  logic [28:0]        m_lat_a_r, m_lat_b_r;
  logic [29:0]        m_dlat_r, m_dlon_r;
  logic [3:0][30:0]   ang_r;

  logic signed [29:0] lac, lbc;
  logic signed [30:0] dlat;
  logic signed [31:0] dlon, dlon_w;
  logic [28:0]        m_lat_a_nxt, m_lat_b_nxt;
  logic [29:0]        m_dlat_nxt, m_dlon_nxt;

  always_comb begin
    lac = (lat_a > LAT_MAX) ? LAT_MAX : ((lat_a < LAT_MIN) ? LAT_MIN : lat_a);
    lbc = (lat_b > LAT_MAX) ? LAT_MAX : ((lat_b < LAT_MIN) ? LAT_MIN : lat_b);
    dlat = {lbc[29], lbc} - {lac[29], lac};
    dlon = {lon_b[30], lon_b} - {lon_a[30], lon_a};
    // one turn is always enough for the input range
    if (dlon > HALF_TURN) begin
      dlon_w = dlon - FULL_TURN;
    end else if (dlon < NEG_HALF_TURN) begin
      dlon_w = dlon + FULL_TURN;
    end else begin
      dlon_w = dlon;
    end
    m_lat_a_nxt = lac[29] ? 29'(-lac) : lac[28:0];
    m_lat_b_nxt = lbc[29] ? 29'(-lbc) : lbc[28:0];
    m_dlat_nxt  = dlat[30] ? 30'(-dlat) : dlat[29:0];
    m_dlon_nxt  = dlon_w[31] ? 30'(-dlon_w) : dlon_w[29:0];
  end

  logic [60:0] p_lat_a, p_lat_b, p_dlat, p_dlon;
  logic [3:0][30:0] ang_nxt;

  always_comb begin
    p_lat_a = 61'(m_lat_a_r) * 61'(RAD_K) + (61'(1) << 27);
    p_lat_b = 61'(m_lat_b_r) * 61'(RAD_K) + (61'(1) << 27);
    p_dlat  = 61'(m_dlat_r)  * 61'(RAD_K) + (61'(1) << 28);
    p_dlon  = 61'(m_dlon_r)  * 61'(RAD_K) + (61'(1) << 28);
    ang_nxt[0] = p_lat_a[58:28];
    ang_nxt[1] = p_lat_b[58:28];
    // half angles for the sin^2 terms
    ang_nxt[2] = p_dlat[59:29];
    ang_nxt[3] = p_dlon[59:29];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    m_lat_a_r <= m_lat_a_nxt;
    m_lat_b_r <= m_lat_b_nxt;
    m_dlat_r  <= m_dlat_nxt;
    m_dlon_r  <= m_dlon_nxt;
    ang_r     <= ang_nxt;
  end

  assign out_valid = v2_r;
  assign ang       = ang_r;

endmodule

FILE: rtl/hvd_cordic_rot.sv
// ----------------------------------------------------------------------------
// hvd_cordic_rot
// four-lane rotation cordic, one iteration per pipeline stage
// ----------------------------------------------------------------------------
module hvd_cordic_rot import hvd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [3:0][30:0] ang,
  output logic             out_valid,
  output q30_t             cos_a,
  output q30_t             cos_b,
  output q30_t             sin_dlat,
  output q30_t             sin_dlon
);

  cw_t              x_r [NSTEPS][4];
  cw_t              y_r [NSTEPS][4];
  cw_t              z_r [NSTEPS][4];
  logic [NSTEPS-1:0] v_r;

  for (genvar s = 0; s < NSTEPS; s++) begin : g_stage
    cw_t  xp [4];
    cw_t  yp [4];
    cw_t  zp [4];
    cw_t  x_nxt [4];
    cw_t  y_nxt [4];
    cw_t  z_nxt [4];
    logic vp;

    if (s == 0) begin : g_head
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          xp[l] = CORDIC_GAIN;
          yp[l] = '0;
          zp[l] = cw_t'({2'b00, ang[l]});
        end
      end
      assign vp = in_valid;
    end else begin : g_tail
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          xp[l] = x_r[s-1][l];
          yp[l] = y_r[s-1][l];
          zp[l] = z_r[s-1][l];
        end
      end
      assign vp = v_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (!zp[l][CW-1]) begin
          x_nxt[l] = xp[l] - (yp[l] >>> s);
          y_nxt[l] = yp[l] + (xp[l] >>> s);
          z_nxt[l] = zp[l] - cw_t'({1'b0, atan_q30(s)});
        end else begin
          x_nxt[l] = xp[l] + (yp[l] >>> s);
          y_nxt[l] = yp[l] - (xp[l] >>> s);
          z_nxt[l] = zp[l] + cw_t'({1'b0, atan_q30(s)});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= vp;
      end
      for (int l = 0; l < 4; l++) begin
        x_r[s][l] <= x_nxt[l];
        y_r[s][l] <= y_nxt[l];
        z_r[s][l] <= z_nxt[l];
      end
    end
  end

  assign out_valid = v_r[NSTEPS-1];
  assign cos_a     = clamp_u31(x_r[NSTEPS-1][0], ONE_Q30);
  assign cos_b     = clamp_u31(x_r[NSTEPS-1][1], ONE_Q30);
  assign sin_dlat  = clamp_u31(y_r[NSTEPS-1][2], ONE_Q30);
  assign sin_dlon  = clamp_u31(y_r[NSTEPS-1][3], ONE_Q30);

endmodule

FILE: rtl/hvd_mix.sv
// ----------------------------------------------------------------------------
// hvd_mix
// forms the haversine term a and 1 - a from the trig results
// ----------------------------------------------------------------------------
module hvd_mix import hvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  q30_t cos_a,
  input  q30_t cos_b,
  input  q30_t sin_dlat,
  input  q30_t sin_dlon,
  output logic out_valid,
  output q30_t hav,
  output q30_t hav_c
);

  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'(1) << 29);
    return p[60:30];
  endfunction

  logic [2:0] v_r;
  q30_t       sdl2_r, cc_r, sdn2_r;
  q30_t       sdl2_d_r, prod_r;
  q30_t       hav_r, hav_c_r;

  logic [31:0] sum;
  q30_t        hav_nxt;

  always_comb begin
    sum     = 32'(sdl2_d_r) + 32'(prod_r);
    hav_nxt = (sum > 32'(ONE_Q30)) ? ONE_Q30 : sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_valid};
    end
    sdl2_r   <= mul_q30(sin_dlat, sin_dlat);
    cc_r     <= mul_q30(cos_a, cos_b);
    sdn2_r   <= mul_q30(sin_dlon, sin_dlon);
    sdl2_d_r <= sdl2_r;
    prod_r   <= mul_q30(cc_r, sdn2_r);
    hav_r    <= hav_nxt;
    hav_c_r  <= ONE_Q30 - hav_nxt;
  end

  assign out_valid = v_r[2];
  assign hav       = hav_r;
  assign hav_c     = hav_c_r;

endmodule

FILE: rtl/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt
// two-lane integer square root of arg * 2^30, one root bit per stage
// ----------------------------------------------------------------------------
module hvd_isqrt import hvd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0][30:0] arg,
  output logic             out_valid,
  output logic [1:0][30:0] root
);

  logic [1:0][60:0]      rem_r  [ISQRT_BITS];
  logic [1:0][30:0]      root_r [ISQRT_BITS];
  logic [ISQRT_BITS-1:0] v_r;

  for (genvar s = 0; s < ISQRT_BITS; s++) begin : g_stage
    localparam int B = ISQRT_BITS - 1 - s;
    logic [1:0][60:0] rem_p, rem_nxt;
    logic [1:0][30:0] root_p, root_nxt;
    logic [1:0][63:0] term;
    logic             vp;

    if (s == 0) begin : g_head
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_p[l]  = {arg[l], 30'b0};
          root_p[l] = '0;
        end
      end
      assign vp = in_valid;
    end else begin : g_tail
      assign rem_p  = rem_r[s-1];
      assign root_p = root_r[s-1];
      assign vp     = v_r[s-1];
    end

    // (r + 2^b)^2 - r^2 against what is left of the radicand
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        term[l] = (64'(root_p[l]) << (B + 1)) | (64'(1) << (2 * B));
        if (term[l] <= 64'(rem_p[l])) begin
          rem_nxt[l]  = rem_p[l] - term[l][60:0];
          root_nxt[l] = root_p[l] | (31'(1) << B);
        end else begin
          rem_nxt[l]  = rem_p[l];
          root_nxt[l] = root_p[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= vp;
      end
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
    end
  end

  assign out_valid = v_r[ISQRT_BITS-1];
  assign root      = root_r[ISQRT_BITS-1];

endmodule

FILE: rtl/hvd_cordic_vec.sv
// ----------------------------------------------------------------------------
// hvd_cordic_vec
// vectoring cordic for atan2(y, x), one iteration per pipeline stage
// ----------------------------------------------------------------------------
module hvd_cordic_vec import hvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  q30_t arg_x,
  input  q30_t arg_y,
  output logic out_valid,
  output q30_t angle
);

  cw_t               x_r [NSTEPS];
  cw_t               y_r [NSTEPS];
  cw_t               z_r [NSTEPS];
  logic [NSTEPS-1:0] v_r;

  for (genvar s = 0; s < NSTEPS; s++) begin : g_stage
    cw_t  xp, yp, zp;
    cw_t  x_nxt, y_nxt, z_nxt;
    logic vp;

    if (s == 0) begin : g_head
      assign xp = cw_t'({2'b00, arg_x});
      assign yp = cw_t'({2'b00, arg_y});
      assign zp = '0;
      assign vp = in_valid;
    end else begin : g_tail
      assign xp = x_r[s-1];
      assign yp = y_r[s-1];
      assign zp = z_r[s-1];
      assign vp = v_r[s-1];
    end

    always_comb begin
      if (!yp[CW-1]) begin
        x_nxt = xp + (yp >>> s);
        y_nxt = yp - (xp >>> s);
        z_nxt = zp + cw_t'({1'b0, atan_q30(s)});
      end else begin
        x_nxt = xp - (yp >>> s);
        y_nxt = yp + (xp >>> s);
        z_nxt = zp - cw_t'({1'b0, atan_q30(s)});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= vp;
      end
      x_r[s] <= x_nxt;
      y_r[s] <= y_nxt;
      z_r[s] <= z_nxt;
    end
  end

  assign out_valid = v_r[NSTEPS-1];
  assign angle     = clamp_u31(z_r[NSTEPS-1], HALF_PI_Q30);

endmodule

FILE: rtl/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance
// great-circle distance between two positions, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   present the two positions on in_lat_a/in_lon_a/in_lat_b/in_lon_b (degrees
//   times 2^22) and raise start; busy stays low, so a transaction is taken
//   at every rising edge with start high, one per cycle without gaps.
//   the distance in km times 2^16 appears on out_distance_km for one cycle
//   with out_valid high, in the order the positions went in.
//   the pipeline has two prep stages, one stage per rotation iteration,
//   three mix stages, 31 square root stages, one stage per vectoring
//   iteration and the final scaling stage.
//   throughput is one result per cycle, set by the one-iteration-per-stage
//   cordic and root pipelines.
//   reset clears every valid bit, so nothing in flight comes out after it;
//   the receiver has no way to stall, so out_valid is never held back.
// ----------------------------------------------------------------------------
module haversine_distance import hvd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [29:0] in_lat_a,
  input  logic signed [30:0] in_lon_a,
  input  logic signed [29:0] in_lat_b,
  input  logic signed [30:0] in_lon_b,
  output logic               out_valid,
  output logic [30:0]        out_distance_km
);

  logic             prep_valid, rot_valid, mix_valid, sq_valid, vec_valid;
  logic [3:0][30:0] ang;
  q30_t             cos_a, cos_b, sin_dlat, sin_dlon;
  q30_t             hav, hav_c;
  logic [1:0][30:0] sq_arg, sq_root;
  q30_t             central;
  logic             out_valid_r;
  logic [30:0]      out_distance_km_r;
  logic [59:0]      scaled;

  assign busy = 1'b0;

  hvd_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .lat_a     (in_lat_a),
    .lon_a     (in_lon_a),
    .lat_b     (in_lat_b),
    .lon_b     (in_lon_b),
    .out_valid (prep_valid),
    .ang       (ang)
  );

  hvd_cordic_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .ang       (ang),
    .out_valid (rot_valid),
    .cos_a     (cos_a),
    .cos_b     (cos_b),
    .sin_dlat  (sin_dlat),
    .sin_dlon  (sin_dlon)
  );

  hvd_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_valid),
    .cos_a     (cos_a),
    .cos_b     (cos_b),
    .sin_dlat  (sin_dlat),
    .sin_dlon  (sin_dlon),
    .out_valid (mix_valid),
    .hav       (hav),
    .hav_c     (hav_c)
  );

  assign sq_arg[0] = hav;
  assign sq_arg[1] = hav_c;

  hvd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mix_valid),
    .arg       (sq_arg),
    .out_valid (sq_valid),
    .root      (sq_root)
  );

  hvd_cordic_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .arg_x     (sq_root[1]),
    .arg_y     (sq_root[0]),
    .out_valid (vec_valid),
    .angle     (central)
  );

  // half the central angle times twice the radius, q2.30 to q16
  assign scaled = 60'(central) * 60'(EARTH_R_Q16) + (60'(1) << 28);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vec_valid;
    end
    out_distance_km_r <= scaled[59:29];
  end

  assign out_valid       = out_valid_r;
  assign out_distance_km = out_distance_km_r;

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_km <= DIST_MAX)
    else $error("distance above half circumference");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("transaction lost in pipeline");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a transaction");

endmodule
